// File: rtl/indexed_min_heap_queue_assert.svh
// Assertion macros for the indexed min-heap queue checker.
`ifndef INDEXED_MIN_HEAP_QUEUE_ASSERT_SVH
`define INDEXED_MIN_HEAP_QUEUE_ASSERT_SVH

// Implication in the same cycle.
`define IMHQ_ASSERT_SAME(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("indexed_min_heap_queue: check failed");

// Implication in the following cycle.
`define IMHQ_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("indexed_min_heap_queue: check failed");

`endif

// File: rtl/imhq_pkg.sv
// Package: types, codes and constants of the indexed min-heap queue.
package imhq_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int NUM_HANDLES  = 64;
  localparam int HANDLE_W     = 6;
  localparam int PRIO_W       = 32;
  localparam int COUNT_W      = 7;
  localparam int STATUS_W     = 3;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_MODIFY = 2'd2;
  localparam logic [1:0] OP_POP    = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NEG    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DUP    = 3'd4;

  typedef struct packed {
    logic [1:0]                 op;
    logic [HANDLE_W-1:0]        handle;
    logic signed [PRIO_W-1:0]   prio;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]        status;
    logic [HANDLE_W-1:0]        popped_handle;
    logic signed [PRIO_W-1:0]   popped_prio;
    logic                       top_valid;
    logic [HANDLE_W-1:0]        top_handle;
    logic signed [PRIO_W-1:0]   top_prio;
    logic [COUNT_W-1:0]         count;
  } rsp_t;

  typedef struct packed {
    logic [HANDLE_W-1:0]        handle;
    logic signed [PRIO_W-1:0]   prio;
  } slot_t;

endpackage

// File: rtl/indexed_min_heap_queue.sv
// Top level: indexed binary min-heap with handle map and a sift sequencer.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | req_t  (op, handle, prio)
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_t  (status, popped, top, count)
//
// A rejected or sift-free transaction goes from S_LOOK via S_TOPRD and S_OUT back to idle.
// One that sifts walks the slot memory level by level before S_PLACE, with a read and a compare
// step per level moved and one that stops it; a walk up that reaches the root stops at once.
// req_ready is high only in idle; a result waiting in the output register stalls the block
// only once the next result is ready. Reset clears the handle map valid bits and count.
module indexed_min_heap_queue
  import imhq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int SLOTS = (CAPACITY < NUM_HANDLES) ? CAPACITY : NUM_HANDLES;
  localparam int PW    = $clog2(SLOTS + 1);
  localparam int AW    = $clog2(SLOTS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOOK  = 4'd1;
  localparam logic [3:0] S_UPRD  = 4'd2;
  localparam logic [3:0] S_UPCMP = 4'd3;
  localparam logic [3:0] S_DNRD  = 4'd4;
  localparam logic [3:0] S_DNCMP = 4'd5;
  localparam logic [3:0] S_PLACE = 4'd6;
  localparam logic [3:0] S_TOPRD = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  slot_t               slot_mem [SLOTS];
  logic [PW-1:0]       pos_mem  [NUM_HANDLES];
  logic [NUM_HANDLES-1:0] pos_valid;

  logic [3:0]          state;
  logic [PW-1:0]       count;
  logic [PW-1:0]       pos;
  logic                first;
  logic [1:0]          op;
  logic [HANDLE_W-1:0] hnd;
  logic signed [PRIO_W-1:0] prio;
  slot_t               cur;
  slot_t               popped;
  logic [STATUS_W-1:0] status;
  slot_t               rd_a;
  slot_t               rd_b;
  logic [PW-1:0]       pos_rd;
  logic                pos_hit;

  logic [AW-1:0]       ra;
  logic [AW-1:0]       rb;
  logic                we;
  logic [AW-1:0]       wa;
  slot_t               wd;
  logic                pwe;
  logic [HANDLE_W-1:0] pwa;
  logic [PW-1:0]       pwd;

  logic [PW:0]         lchild;
  logic [PW:0]         rchild;
  logic [PW:0]         par_m1;
  logic [PW:0]         last_m1;
  logic                take_l;
  logic                take_r;
  logic signed [PRIO_W-1:0] best_p;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    lchild  = {pos, 1'b0};
    rchild  = lchild + 1'b1;
    par_m1  = ({1'b0, pos} >> 1) - 1'b1;
    last_m1 = {1'b0, count} - 1'b1;
    take_l  = (lchild <= {1'b0, count}) && (rd_a.prio < cur.prio);
    best_p  = take_l ? rd_a.prio : cur.prio;
    take_r  = (rchild <= {1'b0, count}) && (rd_b.prio < best_p);
  end

  always_comb begin
    ra  = '0;
    rb  = last_m1[AW-1:0];
    we  = 1'b0;
    wa  = par_m1[AW-1:0];
    wd  = cur;
    pwe = 1'b0;
    pwa = cur.handle;
    pwd = pos;
    case (state)
      S_UPRD: begin
        ra = par_m1[AW-1:0];
      end
      S_UPCMP: begin
        if (cur.prio < rd_a.prio) begin
          we  = 1'b1;
          wa  = AW'(pos - 1'b1);
          wd  = rd_a;
          pwe = 1'b1;
          pwa = rd_a.handle;
        end
      end
      S_DNRD: begin
        ra = AW'(lchild - 1'b1);
        rb = lchild[AW-1:0];
      end
      S_DNCMP: begin
        wa  = AW'(pos - 1'b1);
        if (take_r) begin
          we  = 1'b1;
          wd  = rd_b;
          pwe = 1'b1;
          pwa = rd_b.handle;
        end else if (take_l) begin
          we  = 1'b1;
          wd  = rd_a;
          pwe = 1'b1;
          pwa = rd_a.handle;
        end
      end
      S_PLACE: begin
        we  = 1'b1;
        wa  = AW'(pos - 1'b1);
        pwe = 1'b1;
      end
      default: begin
        ra = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      slot_mem[wa] <= wd;
    end
    rd_a <= slot_mem[ra];
    rd_b <= slot_mem[rb];
  end

  always_ff @(posedge clk) begin
    if (pwe) begin
      pos_mem[pwa] <= pwd;
    end
    pos_rd <= pos_mem[req.handle];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pos_valid <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && (state != S_OUT)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op      <= req.op;
            hnd     <= req.handle;
            prio    <= req.prio;
            pos_hit <= pos_valid[req.handle];
            status  <= ST_OK;
            popped  <= '0;
            state   <= S_LOOK;
          end
        end
        S_LOOK: begin
          state <= S_TOPRD;
          first <= 1'b1;
          case (op)
            OP_INSERT: begin
              if (prio < 0) begin
                status <= ST_NEG;
              end else if (pos_hit) begin
                status <= ST_DUP;
              end else if ({1'b0, count} >= (PW + 1)'(SLOTS)) begin
                status <= ST_FULL;
              end else begin
                count      <= count + 1'b1;
                pos        <= count + 1'b1;
                cur.handle <= hnd;
                cur.prio   <= prio;
                state      <= S_UPRD;
              end
            end
            OP_REMOVE: begin
              if (!pos_hit) begin
                status <= ST_ABSENT;
              end else begin
                pos_valid[hnd] <= 1'b0;
                count          <= count - 1'b1;
                if (pos_rd != count) begin
                  cur   <= rd_b;
                  pos   <= pos_rd;
                  state <= S_UPRD;
                end
              end
            end
            OP_MODIFY: begin
              if (!pos_hit) begin
                status <= ST_ABSENT;
              end else begin
                cur.handle <= hnd;
                cur.prio   <= prio;
                pos        <= pos_rd;
                state      <= S_UPRD;
              end
            end
            default: begin
              if (count == '0) begin
                status <= ST_ABSENT;
              end else begin
                popped                 <= rd_a;
                pos_valid[rd_a.handle] <= 1'b0;
                count                  <= count - 1'b1;
                if (count != PW'(1)) begin
                  cur   <= rd_b;
                  pos   <= PW'(1);
                  state <= S_UPRD;
                end
              end
            end
          endcase
        end
        S_UPRD: begin
          if (pos > PW'(1)) begin
            state <= S_UPCMP;
          end else begin
            state <= first ? S_DNRD : S_PLACE;
          end
        end
        S_UPCMP: begin
          if (cur.prio < rd_a.prio) begin
            pos   <= pos >> 1;
            first <= 1'b0;
            state <= S_UPRD;
          end else begin
            state <= first ? S_DNRD : S_PLACE;
          end
        end
        S_DNRD: begin
          state <= S_DNCMP;
        end
        S_DNCMP: begin
          if (take_r) begin
            pos   <= rchild[PW-1:0];
            state <= S_DNRD;
          end else if (take_l) begin
            pos   <= lchild[PW-1:0];
            state <= S_DNRD;
          end else begin
            state <= S_PLACE;
          end
        end
        S_PLACE: begin
          pos_valid[cur.handle] <= 1'b1;
          state                 <= S_TOPRD;
        end
        S_TOPRD: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid         <= 1'b1;
            rsp.status        <= status;
            rsp.popped_handle <= popped.handle;
            rsp.popped_prio   <= popped.prio;
            rsp.top_valid     <= (count != '0);
            rsp.top_handle    <= (count != '0) ? rd_a.handle : '0;
            rsp.top_prio      <= (count != '0) ? rd_a.prio : '0;
            rsp.count         <= COUNT_W'(count);
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/imhq_checker.sv
// Checker: port-level assertions for the indexed min-heap queue, with its bind.
`include "indexed_min_heap_queue_assert.svh"

module imhq_checker
  import imhq_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  `IMHQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
  `IMHQ_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)
  `IMHQ_ASSERT_SAME(a_top_matches_count, rsp_valid, rsp.top_valid == (rsp.count != '0))
  `IMHQ_ASSERT_SAME(a_fail_no_pop, rsp_valid && rsp.status != ST_OK, rsp.popped_handle == '0 && rsp.popped_prio == '0)

endmodule

bind indexed_min_heap_queue imhq_checker u_imhq_checker (.*);
